FILE: hdl/spq_pkg.sv
package spq_pkg;

  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_POP    = 2'd1;
  localparam logic [1:0] REQ_PEEK   = 2'd2;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  localparam logic [1:0] MODE_TIME_ASC  = 2'd0;
  localparam logic [1:0] MODE_DEST_ASC  = 2'd1;
  localparam logic [1:0] MODE_DEST_DESC = 2'd2;

  typedef struct packed {
    logic [31:0] stamp;
    logic [7:0]  source;
    logic [7:0]  dest;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_EV,
    S_HD_RD,
    S_HD_EV,
    S_POP_RD,
    S_POP_EV
  } state_t;

  function automatic logic ranks_after(logic [1:0] mode, entry_t n, entry_t s);
    logic res;
    unique case (mode)
      MODE_TIME_ASC:  res = n.stamp > s.stamp;
      MODE_DEST_ASC:  res = n.dest > s.dest;
      MODE_DEST_DESC: res = n.dest < s.dest;
      default:        res = 1'b0;
    endcase
    return res;
  endfunction

endpackage

FILE: hdl/spq_in_if.sv
interface spq_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [31:0] entry_time;
  logic [7:0]  entry_source;
  logic [7:0]  entry_dest;

  modport source (output valid, req_type, entry_time, entry_source, entry_dest,
                  input ready);
  modport sink (input valid, req_type, entry_time, entry_source, entry_dest,
                output ready);
endinterface

FILE: hdl/spq_out_if.sv
interface spq_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] head_time;
  logic [7:0]  head_source;
  logic [7:0]  head_dest;
  logic [4:0]  count;

  modport source (output valid, status, head_time, head_source, head_dest, count,
                  input ready);
  modport sink (input valid, status, head_time, head_source, head_dest, count,
                output ready);
endinterface

FILE: hdl/sorted_priority_queue.sv
// Insert reads and evaluates each stored entry in turn from the head; pop reads
// the head, then moves each later entry down one place; peek reads the head only.
// All use the single entry RAM. Dropped, empty and no-op requests are answered
// in the cycle after acceptance. One request is in flight at a time: the next is
// accepted no earlier than the edge at which the previous result is taken.
// Synchronous active-low reset empties the queue and selects time ascending order.
module sorted_priority_queue #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  spq_in_if.sink     in_ch,
  spq_out_if.source  out_ch,
  input  logic       cfg_we,
  input  logic [1:0] cfg_wdata
);
  import spq_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  state_t          state_r, state_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [CW-1:0]   idx_r, idx_nxt;
  logic [CW-1:0]   idx_m1;
  entry_t          carry_r, carry_nxt;
  logic            placed_r, placed_nxt;
  logic [1:0]      op_r, op_nxt;
  logic [1:0]      mode_r;
  logic            out_valid_r, out_valid_nxt;
  logic [1:0]      out_status_r, out_status_nxt;
  entry_t          out_head_r, out_head_nxt;
  logic [4:0]      out_count_r, out_count_nxt;

  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  entry_t          ram_wdata;
  logic [AW-1:0]   ram_raddr;
  entry_t          ram_rdata;
  logic            in_acc;
  entry_t          new_entry;

  spq_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_ch.ready = (state_r == S_IDLE) && (!out_valid_r || out_ch.ready);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign new_entry   = '{stamp: in_ch.entry_time, source: in_ch.entry_source,
                         dest: in_ch.entry_dest};
  assign idx_m1      = idx_r - CW'(1);

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.head_time   = out_head_r.stamp;
  assign out_ch.head_source = out_head_r.source;
  assign out_ch.head_dest   = out_head_r.dest;
  assign out_ch.count       = out_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      mode_r      <= MODE_TIME_ASC;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        mode_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    carry_r      <= carry_nxt;
    placed_r     <= placed_nxt;
    op_r         <= op_nxt;
    out_status_r <= out_status_nxt;
    out_head_r   <= out_head_nxt;
    out_count_r  <= out_count_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    idx_nxt        = idx_r;
    carry_nxt      = carry_r;
    placed_nxt     = placed_r;
    op_nxt         = op_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_head_nxt   = out_head_r;
    out_count_nxt  = out_count_r;
    ram_we         = 1'b0;
    ram_waddr      = idx_r[AW-1:0];
    ram_wdata      = carry_r;
    ram_raddr      = idx_r[AW-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          op_nxt        = in_ch.req_type;
          idx_nxt       = '0;
          out_head_nxt  = '0;
          out_count_nxt = 5'(cnt_r);
          unique case (in_ch.req_type) inside
            REQ_INSERT: begin
              if (cnt_r == CW'(QUEUE_DEPTH)) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = STAT_FULL;
              end else begin
                carry_nxt  = new_entry;
                placed_nxt = 1'b0;
                state_nxt  = S_INS_RD;
              end
            end
            REQ_POP, REQ_PEEK: begin
              if (cnt_r == '0) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = STAT_EMPTY;
              end else begin
                state_nxt = S_HD_RD;
              end
            end
            default: begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = STAT_OK;
            end
          endcase
        end
      end
      S_INS_RD: begin
        if (idx_r == cnt_r) begin
          ram_we         = 1'b1;
          cnt_nxt        = cnt_r + CW'(1);
          out_valid_nxt  = 1'b1;
          out_status_nxt = STAT_OK;
          out_head_nxt   = '0;
          out_count_nxt  = 5'(cnt_r + CW'(1));
          state_nxt      = S_IDLE;
        end else begin
          state_nxt = S_INS_EV;
        end
      end
      S_INS_EV: begin
        if (placed_r || !ranks_after(mode_r, carry_r, ram_rdata)) begin
          ram_we     = 1'b1;
          carry_nxt  = ram_rdata;
          placed_nxt = 1'b1;
        end
        idx_nxt   = idx_r + CW'(1);
        state_nxt = S_INS_RD;
      end
      S_HD_RD: begin
        state_nxt = S_HD_EV;
      end
      S_HD_EV: begin
        carry_nxt = ram_rdata;
        if (op_r == REQ_PEEK) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = STAT_OK;
          out_head_nxt   = ram_rdata;
          out_count_nxt  = 5'(cnt_r);
          state_nxt      = S_IDLE;
        end else begin
          idx_nxt   = CW'(1);
          state_nxt = S_POP_RD;
        end
      end
      S_POP_RD: begin
        if (idx_r == cnt_r) begin
          cnt_nxt        = cnt_r - CW'(1);
          out_valid_nxt  = 1'b1;
          out_status_nxt = STAT_OK;
          out_head_nxt   = carry_r;
          out_count_nxt  = 5'(cnt_r - CW'(1));
          state_nxt      = S_IDLE;
        end else begin
          state_nxt = S_POP_EV;
        end
      end
      S_POP_EV: begin
        ram_we    = 1'b1;
        ram_waddr = idx_m1[AW-1:0];
        ram_wdata = ram_rdata;
        idx_nxt   = idx_r + CW'(1);
        state_nxt = S_POP_RD;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

FILE: hdl/spq_ram.sv
module spq_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/spq_chk.sv
module spq_chk #(
  parameter int QUEUE_DEPTH = 16
) (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_status,
  input logic [31:0] out_head_time,
  input logic [7:0]  out_head_source,
  input logic [7:0]  out_head_dest,
  input logic [4:0]  out_count
);
  import spq_pkg::*;

  // A pending result must be taken before the next transaction is accepted.
  assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid && !out_ready))
    else $error("input accepted while a result is stalled");

  // Each accepted transaction either answers at once or holds the input off.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid || !in_ready)
    else $error("input left open while a transaction is in progress");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn before it was taken");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STAT_EMPTY |->
      out_head_time == '0 && out_head_source == '0 && out_head_dest == '0 &&
      out_count == '0)
    else $error("empty result carries data or a nonzero count");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STAT_FULL |-> out_count == 5'(QUEUE_DEPTH))
    else $error("full result with a count other than the depth");

endmodule

bind sorted_priority_queue spq_chk #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_spq_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_status      (out_ch.status),
  .out_head_time   (out_ch.head_time),
  .out_head_source (out_ch.head_source),
  .out_head_dest   (out_ch.head_dest),
  .out_count       (out_ch.count)
);
